// ----- rtl/assert_macros.svh -----
// Assertion macros used by the top level of the envelope follower.
// Active only when SYNTH is not defined; empty bodies otherwise.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
// property must hold at every clock edge out of reset
`define ASSERT_CLK(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
		else $error("assertion failed");
// condition must never be true out of reset
`define ASSERT_NEVER(lbl, clk, rst_n, cond) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) !(cond)) \
		else $error("forbidden condition seen");
`else
`define ASSERT_CLK(lbl, clk, rst_n, prop)
`define ASSERT_NEVER(lbl, clk, rst_n, cond)
`endif

`endif

// ----- rtl/wpef_pkg.sv -----
// Package for the windowed peak envelope follower: constants, codes, state type.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package wpef_pkg;
	localparam int ENV_DEPTH_DEF = 1024;

	localparam logic [11:0] WLEN_RST   = 12'd352;
	localparam logic [10:0] WCNT_RST   = 11'd1024;
	localparam logic [22:0] FILL_MAX   = 23'h7FFFFF;
	localparam logic [14:0] PEAK_FLOOR = 15'd983;
	localparam logic [9:0]  GATE_LEVEL = 10'd655;
	localparam logic [14:0] MAG_MAX    = 15'd32767;
	localparam logic [21:0] FULL_OPEN  = 22'd32768;

	// serial divider geometry
	localparam int DIV_NW = 22;
	localparam int DIV_DW = 27;

	// input kinds
	localparam logic [1:0] MODE_APPEND = 2'd0;
	localparam logic [1:0] MODE_QUERY  = 2'd1;
	localparam logic [1:0] MODE_START  = 2'd2;

	// register indexes
	localparam logic [1:0] REG_WLEN = 2'd0;
	localparam logic [1:0] REG_WCNT = 2'd1;

	typedef enum logic [3:0] {
		ST_IDLE, ST_DIV1, ST_CHK, ST_RDA, ST_RDB,
		ST_MULA, ST_MULB, ST_GATE, ST_DIV2, ST_FIN
	} state_t;
endpackage
`default_nettype wire

// ----- rtl/wpef_ram.sv -----
// Generic single write port, single read port RAM with registered read.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
module wpef_ram #(
	parameter int WIDTH = 15,
	parameter int DEPTH = 1024
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule
`default_nettype wire

// ----- rtl/wpef_sdiv.sv -----
// Bit-serial restoring divider: one quotient bit per cycle, numerator shifted in.
// Uses wpef_pkg for its geometry.
`timescale 1ns / 1ps
`default_nettype none
module wpef_sdiv (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       start,
	input  wire logic [wpef_pkg::DIV_DW-1:0] rem0,
	input  wire logic [wpef_pkg::DIV_NW-1:0] num,
	input  wire logic [wpef_pkg::DIV_DW-1:0] den,
	output logic                            busy,
	output logic                            done,
	output logic      [wpef_pkg::DIV_NW-1:0] quot,
	output logic      [wpef_pkg::DIV_DW-1:0] rem
);
	import wpef_pkg::*;

	localparam int CW = $clog2(DIV_NW + 1);

	logic [DIV_DW-1:0] rem_q, den_q;
	logic [DIV_NW-1:0] num_q, quot_q;
	logic [CW-1:0]     cnt_q;
	logic              busy_q, done_q;
	logic [DIV_DW:0]   trial;
	logic              fits;

	// one restoring step
	assign trial = {rem_q, num_q[DIV_NW-1]};
	assign fits  = trial >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CW'(DIV_NW - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q  <= rem0;
			num_q  <= num;
			den_q  <= den;
			quot_q <= '0;
		end else if (busy_q) begin
			rem_q  <= fits ? DIV_DW'(trial - {1'b0, den_q}) : trial[DIV_DW-1:0];
			num_q  <= {num_q[DIV_NW-2:0], 1'b0};
			quot_q <= {quot_q[DIV_NW-2:0], fits};
		end
	end

	assign busy = busy_q;
	assign done = done_q;
	assign quot = quot_q;
	assign rem  = rem_q;
endmodule
`default_nettype wire

// ----- rtl/windowed_peak_envelope_follower.sv -----
// Top level of the windowed peak envelope follower: append, start, query.
// Depends on wpef_pkg, wpef_ram, wpef_sdiv and assert_macros.svh.
//
//  channel | dir | handshake        | payload
//  s_*     | in  | s_tvalid/tready  | tuser=mode, tdata=sample,position,position_valid
//  m_*     | out | m_tvalid/tready  | tdata=mouth_level
//  cfg_*   | in  | cfg_valid/ready  | cfg_index, cfg_data
//
// Append, start and unused kinds are handled in the idle state without leaving it. A full
// query runs two 22-step passes of the serial divider (window index, then normalization),
// two RAM reads and two multiply steps; no new input is accepted until it ends. Queries
// end early at accept (early-out), past the end of the store, or when gated.
// The peak store needs no clearing: a fill mark (window index) decides which
// entries are live. A finished result waits in the output register; a query
// done while it is still held stalls until it is taken.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module windowed_peak_envelope_follower #(
	parameter int ENV_DEPTH = wpef_pkg::ENV_DEPTH_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	// [15:0] sample, [37:16] position, [38] position_valid, [39] zero
	input  wire logic [39:0] s_tdata,
	// [1:0] mode
	input  wire logic [1:0]  s_tuser,
	output logic             m_tvalid,
	input  wire logic        m_tready,
	// [15:0] mouth_level
	output logic      [15:0] m_tdata,
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [11:0] cfg_data
);
	import wpef_pkg::*;

	localparam int AW = $clog2(ENV_DEPTH);

	state_t state_q, state_d;

	logic [11:0] wlen_q;
	logic [10:0] wcnt_q, lim;
	logic [14:0] overall_q, cur_q;
	logic [22:0] filled_q;
	logic [10:0] widx_q;
	logic [11:0] woff_q;

	logic [21:0] pos_q;
	logic [21:0] k_q;
	logic [11:0] off_q;
	logic        interp_q;
	logic [14:0] p0_q, p1_q;
	logic [26:0] acc_q, den_q;
	logic [15:0] level_q, out_q;
	logic        out_valid_q;

	logic        in_acc, early_zero, out_free;
	logic [15:0] smp;
	logic [14:0] mag, newpk, rdata, ent0, ent1, mdiv;
	logic [11:0] k1;
	logic [AW-1:0] raddr;
	logic        we;

	logic              div_start, div_busy, div_done;
	logic [DIV_DW-1:0] div_rem0, div_den, div_rem;
	logic [DIV_NW-1:0] div_num, div_quot;

	logic [21:0] kw;
	logic [23:0] need;
	logic signed [28:0] dprod, esum;

	assign lim = (32'(wcnt_q) < ENV_DEPTH) ? wcnt_q : 11'(ENV_DEPTH);
	assign in_acc = s_tvalid && s_tready;
	assign out_free = !out_valid_q || m_tready;
	assign cfg_ready = 1'b1;

	// sample magnitude, clamped
	assign smp = s_tdata[15:0];
	always_comb begin
		logic [15:0] a;
		a = smp[15] ? 16'(~smp + 16'd1) : smp;
		mag = a[15] ? MAG_MAX : a[14:0];
	end
	assign newpk = (mag > cur_q) ? mag : cur_q;
	assign we = in_acc && s_tuser == MODE_APPEND && wlen_q != 12'd0 && widx_q < lim;

	// query early-outs at accept
	assign early_zero = !s_tdata[38] || {1'b0, s_tdata[37:16]} >= filled_q
		|| wlen_q == 12'd0;

	// peak store
	assign k1 = 12'(k_q[10:0]) + 12'd1;
	wpef_ram #(.WIDTH(15), .DEPTH(ENV_DEPTH)) u_ram (
		.clk(clk), .we(we), .waddr(AW'(widx_q)), .wdata(newpk),
		.raddr(raddr), .rdata(rdata)
	);
	// live entries: below the fill mark from RAM, the open window from cur_q
	assign ent0 = (k_q[10:0] < widx_q) ? rdata : (k_q[10:0] == widx_q ? cur_q : '0);
	assign ent1 = (k1 < 12'(widx_q)) ? rdata : (k1 == 12'(widx_q) ? cur_q : '0);

	// serial divider, shared by both divisions
	assign div_rem0 = (state_q == ST_GATE) ? DIV_DW'(acc_q[26:7]) : '0;
	assign div_num  = (state_q == ST_GATE) ? {acc_q[6:0], 15'd0} : s_tdata[37:16];
	assign div_den  = (state_q == ST_GATE) ? den_q : DIV_DW'(wlen_q);
	wpef_sdiv u_div (
		.clk(clk), .arst_n(arst_n), .start(div_start),
		.rem0(div_rem0), .num(div_num), .den(div_den),
		.busy(div_busy), .done(div_done), .quot(div_quot), .rem(div_rem)
	);

	assign kw   = pos_q - 22'(off_q);
	assign need = 24'(kw) + {11'd0, wlen_q, 1'b0};
	assign mdiv = (overall_q < PEAK_FLOOR) ? PEAK_FLOOR : overall_q;
	assign dprod = $signed({17'd0, off_q}) * ($signed({14'd0, p1_q}) - $signed({14'd0, p0_q}));
	assign esum = $signed({2'b00, acc_q}) + dprod;

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_acc && s_tuser == MODE_QUERY) begin
					state_d = early_zero ? ST_FIN : ST_DIV1;
				end
			end
			ST_DIV1: if (div_done) state_d = ST_CHK;
			ST_CHK:  state_d = (k_q >= 22'(lim)) ? ST_FIN : ST_RDA;
			ST_RDA:  state_d = ST_RDB;
			ST_RDB:  state_d = ST_MULA;
			ST_MULA: state_d = ST_MULB;
			ST_MULB: state_d = ST_GATE;
			ST_GATE: state_d = (acc_q < 27'(GATE_LEVEL * wlen_q)) ? ST_FIN : ST_DIV2;
			ST_DIV2: if (div_done) state_d = ST_FIN;
			ST_FIN:  if (out_free) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	// state outputs
	always_comb begin
		s_tready  = state_q == ST_IDLE;
		div_start = 1'b0;
		raddr     = AW'(k_q[10:0]);
		case (state_q)
			ST_IDLE: div_start = s_tvalid && s_tuser == MODE_QUERY && !early_zero;
			ST_RDB:  raddr = AW'(k1);
			ST_GATE: div_start = acc_q >= 27'(GATE_LEVEL * wlen_q);
			default: ;
		endcase
	end

	// control and utterance state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			wlen_q      <= WLEN_RST;
			wcnt_q      <= WCNT_RST;
			overall_q   <= '0;
			cur_q       <= '0;
			filled_q    <= '0;
			widx_q      <= '0;
			woff_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_valid) begin
				case (cfg_index)
					REG_WLEN: wlen_q <= cfg_data;
					REG_WCNT: wcnt_q <= cfg_data[10:0];
					default: ;
				endcase
			end
			if (in_acc) begin
				case (s_tuser)
					MODE_APPEND: begin
						if (we) begin
							if (mag > overall_q) overall_q <= mag;
							if (13'(woff_q) + 13'd1 >= 13'(wlen_q)) begin
								woff_q <= '0;
								widx_q <= widx_q + 11'd1;
								cur_q  <= '0;
							end else begin
								woff_q <= woff_q + 12'd1;
								cur_q  <= newpk;
							end
						end
						if (filled_q < FILL_MAX) filled_q <= filled_q + 23'd1;
					end
					MODE_START: begin
						overall_q <= '0;
						cur_q     <= '0;
						filled_q  <= '0;
						widx_q    <= '0;
						woff_q    <= '0;
					end
					default: ;
				endcase
			end
			if (state_q == ST_FIN && out_free) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// query datapath
	always_ff @(posedge clk) begin
		if (in_acc) begin
			pos_q   <= s_tdata[37:16];
			level_q <= '0;
		end
		if (state_q == ST_DIV1 && div_done) begin
			k_q   <= div_quot;
			off_q <= div_rem[11:0];
		end
		if (state_q == ST_CHK) begin
			level_q  <= '0;
			interp_q <= (12'(k_q[10:0]) + 12'd1 < 12'(lim)) && need <= 24'(filled_q);
		end
		if (state_q == ST_RDA) den_q <= 27'(wlen_q * mdiv);
		if (state_q == ST_RDB) p0_q <= ent0;
		if (state_q == ST_MULA) begin
			p1_q  <= interp_q ? ent1 : p0_q;
			acc_q <= 27'(p0_q * wlen_q);
		end
		if (state_q == ST_MULB) acc_q <= esum[26:0];
		if (state_q == ST_GATE) level_q <= '0;
		if (state_q == ST_DIV2 && div_done) begin
			level_q <= (div_quot > FULL_OPEN) ? 16'h8000 : div_quot[15:0];
		end
		if (state_q == ST_FIN && out_free) out_q <= level_q;
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_q;

	`ASSERT_CLK(a_div_owner, clk, arst_n, div_busy |-> (state_q == ST_DIV1 || state_q == ST_DIV2))
	`ASSERT_CLK(a_query_leaves_idle, clk, arst_n, (in_acc && s_tuser == MODE_QUERY) |=> state_q != ST_IDLE)
	`ASSERT_NEVER(a_level_sat, clk, arst_n, state_q == ST_FIN && level_q > 16'h8000)
	`ASSERT_NEVER(a_no_write_in_query, clk, arst_n, we && state_q != ST_IDLE)
endmodule
`default_nettype wire
